// ===== design/cssbag_pkg.sv =====
package cssbag_pkg;

   localparam int ADDR_WIDTH_DEFAULT = 24;

   localparam int COUNT_WIDTH  = 8;
   localparam int OFFSET_WIDTH = 24;
   localparam int PITCH_WIDTH  = 16;
   localparam int DIM_WIDTH    = 12;
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 16;

   localparam int REQ_DATA_WIDTH = 2 * COUNT_WIDTH;
   localparam int RSP_DATA_WIDTH = 2 * OFFSET_WIDTH + COUNT_WIDTH;

   localparam logic [PITCH_WIDTH-1:0] DEST_PITCH_RESET   = PITCH_WIDTH'(640);
   localparam logic [DIM_WIDTH-1:0]   IMAGE_WIDTH_RESET  = DIM_WIDTH'(1);
   localparam logic [DIM_WIDTH-1:0]   IMAGE_HEIGHT_RESET = DIM_WIDTH'(1);

   typedef enum logic [CSR_ADDR_WIDTH-1:0] {
      REG_SOURCE_MODE  = 3'd0,
      REG_DEST_X       = 3'd1,
      REG_DEST_Y       = 3'd2,
      REG_DEST_PITCH   = 3'd3,
      REG_SOURCE_PITCH = 3'd4,
      REG_IMAGE_WIDTH  = 3'd5,
      REG_IMAGE_HEIGHT = 3'd6
   } reg_index_type;

endpackage

// ===== design/copy_skip_span_blit_address_gen.sv =====
// An accepted req item passes through the input register and then the result register to its rsp item.
// Throughput: one item per cycle while rsp_tready holds no stall; pointer updates are adds between the two registers.
// The sprite origin product is registered at each csr write, so the first item of an image
// sees it at once.
// Reset (synchronous, active high) empties both stages, clears pointers and row count,
// and restores register defaults.
module copy_skip_span_blit_address_gen #(
   parameter int ADDR_WIDTH = cssbag_pkg::ADDR_WIDTH_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   // copy_count [7:0], skip_count [15:8]
   input  logic [cssbag_pkg::REQ_DATA_WIDTH-1:0]   req_tdata,
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   // dest_offset [23:0], source_offset [47:24], copy_length [55:48]
   output logic [cssbag_pkg::RSP_DATA_WIDTH-1:0]   rsp_tdata,
   // row_end [0]
   output logic                                    rsp_tuser,
   output logic                                    rsp_tlast,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [cssbag_pkg::CSR_ADDR_WIDTH-1:0]   csr_addr,
   input  logic [cssbag_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);

   localparam int CW = cssbag_pkg::COUNT_WIDTH;
   localparam int OW = cssbag_pkg::OFFSET_WIDTH;
   localparam int PW = cssbag_pkg::PITCH_WIDTH;
   localparam int DW = cssbag_pkg::DIM_WIDTH;

   logic          source_mode_ff, source_mode_in;
   logic [PW-1:0] dest_x_ff, dest_x_in;
   logic [PW-1:0] dest_y_ff, dest_y_in;
   logic [PW-1:0] dest_pitch_ff, dest_pitch_in;
   logic [PW-1:0] source_pitch_ff, source_pitch_in;
   logic [DW-1:0] image_width_ff, image_width_in;
   logic [DW-1:0] image_height_ff, image_height_in;
   logic [ADDR_WIDTH-1:0] origin_ff, origin_in;
   logic [2*PW-1:0] origin_prod;
   logic [2*PW:0]   origin_sum;

   logic [ADDR_WIDTH-1:0] dest_ptr_ff, dest_ptr_in;
   logic [ADDR_WIDTH-1:0] src_ptr_ff, src_ptr_in;
   logic [DW-1:0]         rows_done_ff, rows_done_in;
   logic                  in_progress_ff, in_progress_in;

   logic          s1_valid_ff;
   logic [CW-1:0] s1_copy_ff, s1_skip_ff;
   logic          s1_advance, out_free;

   logic [ADDR_WIDTH-1:0] cur_dest, cur_src;
   logic [DW-1:0]         cur_rows;
   logic [DW-1:0]         height_eff;
   logic [CW:0]           span;
   logic [ADDR_WIDTH-1:0] row_adjust_dest, row_adjust_src;
   logic                  is_row_end, is_done;

   logic [OW-1:0] out_dest_ff, out_src_ff;
   logic [CW-1:0] out_len_ff;
   logic          out_row_end_ff, out_done_ff, out_valid_ff;

   assign csr_ready = 1'b1;

   always_comb begin
      source_mode_in  = source_mode_ff;
      dest_x_in       = dest_x_ff;
      dest_y_in       = dest_y_ff;
      dest_pitch_in   = dest_pitch_ff;
      source_pitch_in = source_pitch_ff;
      image_width_in  = image_width_ff;
      image_height_in = image_height_ff;
      if (csr_valid) begin
         unique case (csr_addr)
            cssbag_pkg::REG_SOURCE_MODE:  source_mode_in  = csr_wdata[0];
            cssbag_pkg::REG_DEST_X:       dest_x_in       = csr_wdata;
            cssbag_pkg::REG_DEST_Y:       dest_y_in       = csr_wdata;
            cssbag_pkg::REG_DEST_PITCH:   dest_pitch_in   = csr_wdata;
            cssbag_pkg::REG_SOURCE_PITCH: source_pitch_in = csr_wdata;
            cssbag_pkg::REG_IMAGE_WIDTH:  image_width_in  = csr_wdata[DW-1:0];
            cssbag_pkg::REG_IMAGE_HEIGHT: image_height_in = csr_wdata[DW-1:0];
            default: ;
         endcase
      end
      origin_prod = dest_y_in * dest_pitch_in;
      origin_sum  = {1'b0, origin_prod} + {{(PW+1){1'b0}}, dest_x_in};
      origin_in   = ADDR_WIDTH'(origin_sum);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         source_mode_ff  <= 1'b0;
         dest_x_ff       <= '0;
         dest_y_ff       <= '0;
         dest_pitch_ff   <= cssbag_pkg::DEST_PITCH_RESET;
         source_pitch_ff <= '0;
         image_width_ff  <= cssbag_pkg::IMAGE_WIDTH_RESET;
         image_height_ff <= cssbag_pkg::IMAGE_HEIGHT_RESET;
         origin_ff       <= '0;
      end else begin
         source_mode_ff  <= source_mode_in;
         dest_x_ff       <= dest_x_in;
         dest_y_ff       <= dest_y_in;
         dest_pitch_ff   <= dest_pitch_in;
         source_pitch_ff <= source_pitch_in;
         image_width_ff  <= image_width_in;
         image_height_ff <= image_height_in;
         origin_ff       <= origin_in;
      end
   end

   assign out_free   = !out_valid_ff || rsp_tready;
   assign s1_advance = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_copy_ff <= req_tdata[CW-1:0];
         s1_skip_ff <= req_tdata[2*CW-1:CW];
      end
   end

   always_comb begin
      cur_dest = dest_ptr_ff;
      cur_src  = src_ptr_ff;
      cur_rows = rows_done_ff;
      if (!in_progress_ff) begin
         cur_dest = source_mode_ff ? '0 : origin_ff;
         cur_src  = '0;
         cur_rows = '0;
      end
      height_eff = (image_height_ff == '0) ? DW'(1) : image_height_ff;
      is_row_end = (s1_copy_ff == '0) && (s1_skip_ff == '0);
      span = {1'b0, s1_copy_ff} + {1'b0, s1_skip_ff};
      row_adjust_dest = ADDR_WIDTH'(dest_pitch_ff) - ADDR_WIDTH'(image_width_ff);
      row_adjust_src  = ADDR_WIDTH'(source_pitch_ff) - ADDR_WIDTH'(image_width_ff);

      rows_done_in   = cur_rows;
      in_progress_in = 1'b1;
      is_done        = 1'b0;
      if (is_row_end) begin
         dest_ptr_in  = cur_dest + row_adjust_dest;
         src_ptr_in   = (source_mode_ff && source_pitch_ff != '0) ?
                        cur_src + row_adjust_src : cur_src;
         rows_done_in = cur_rows + DW'(1);
         if (rows_done_in >= height_eff) begin
            is_done        = 1'b1;
            in_progress_in = 1'b0;
         end
      end else begin
         dest_ptr_in = cur_dest + ADDR_WIDTH'(span);
         src_ptr_in  = source_mode_ff ? cur_src + ADDR_WIDTH'(span)
                                      : cur_src + ADDR_WIDTH'(s1_copy_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dest_ptr_ff    <= '0;
         src_ptr_ff     <= '0;
         rows_done_ff   <= '0;
         in_progress_ff <= 1'b0;
      end else if (s1_advance) begin
         dest_ptr_ff    <= dest_ptr_in;
         src_ptr_ff     <= src_ptr_in;
         rows_done_ff   <= rows_done_in;
         in_progress_ff <= in_progress_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         out_dest_ff    <= OW'(cur_dest);
         out_src_ff     <= OW'(cur_src);
         out_len_ff     <= s1_copy_ff;
         out_row_end_ff <= is_row_end;
         out_done_ff    <= is_done;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_len_ff, out_src_ff, out_dest_ff};
   assign rsp_tuser  = out_row_end_ff;
   assign rsp_tlast  = out_done_ff;

endmodule

// ===== dv/copy_skip_span_blit_address_gen_tb.sv =====
`timescale 1ns / 1ps

module copy_skip_span_blit_address_gen_tb;

   localparam int AW  = cssbag_pkg::ADDR_WIDTH_DEFAULT;
   localparam int OW  = cssbag_pkg::OFFSET_WIDTH;
   localparam int CW  = cssbag_pkg::COUNT_WIDTH;
   localparam int PW  = cssbag_pkg::PITCH_WIDTH;
   localparam int DW  = cssbag_pkg::DIM_WIDTH;
   localparam int CAW = cssbag_pkg::CSR_ADDR_WIDTH;
   localparam int CDW = cssbag_pkg::CSR_DATA_WIDTH;
   localparam int QDW = cssbag_pkg::REQ_DATA_WIDTH;
   localparam int RDW = cssbag_pkg::RSP_DATA_WIDTH;
   localparam int RANDOM_ITEMS = 1650;
   localparam int QUIET_TAIL = 200;
   localparam int STALL_LIMIT = 2000;

   typedef struct packed {
      logic [OW-1:0] dest_offset;
      logic [OW-1:0] source_offset;
      logic [CW-1:0] copy_length;
      logic          row_end;
      logic          image_done;
   } descriptor_type;

   class descriptor_scoreboard_type;
      bit                 mode;
      bit [PW-1:0]        origin_x;
      bit [PW-1:0]        origin_y;
      bit [PW-1:0]        dest_pitch;
      bit [PW-1:0]        source_pitch;
      bit [DW-1:0]        width;
      bit [DW-1:0]        height;
      bit [AW-1:0]        dest_ptr;
      bit [AW-1:0]        source_ptr;
      bit [DW-1:0]        rows_done;
      bit                 busy;
      descriptor_type     expected_descriptors[$];
      int                 failures;

      function new();
         mode = 1'b0;
         origin_x = '0;
         origin_y = '0;
         dest_pitch = cssbag_pkg::DEST_PITCH_RESET;
         source_pitch = '0;
         width = cssbag_pkg::IMAGE_WIDTH_RESET;
         height = cssbag_pkg::IMAGE_HEIGHT_RESET;
         dest_ptr = '0;
         source_ptr = '0;
         rows_done = '0;
         busy = 1'b0;
         failures = 0;
      endfunction

      function void write_reg(cssbag_pkg::reg_index_type idx, bit [CDW-1:0] value);
         case (idx)
            cssbag_pkg::REG_SOURCE_MODE: mode = value[0];
            cssbag_pkg::REG_DEST_X: origin_x = value;
            cssbag_pkg::REG_DEST_Y: origin_y = value;
            cssbag_pkg::REG_DEST_PITCH: dest_pitch = value;
            cssbag_pkg::REG_SOURCE_PITCH: source_pitch = value;
            cssbag_pkg::REG_IMAGE_WIDTH: width = value[DW-1:0];
            cssbag_pkg::REG_IMAGE_HEIGHT: height = value[DW-1:0];
            default: ;
         endcase
      endfunction

      function void note_instruction(bit [CW-1:0] copy, bit [CW-1:0] skip);
         descriptor_type d;
         bit [DW-1:0] rows_needed;
         bit [63:0] origin;
         if (!busy) begin
            origin = 64'(origin_y) * 64'(dest_pitch) + 64'(origin_x);
            dest_ptr = mode ? '0 : origin[AW-1:0];
            source_ptr = '0;
            rows_done = '0;
            busy = 1'b1;
         end
         d = '0;
         d.dest_offset = dest_ptr[OW-1:0];
         d.source_offset = source_ptr[OW-1:0];
         d.copy_length = copy;
         if (copy == 0 && skip == 0) begin
            rows_needed = (height == 0) ? DW'(1) : height;
            d.row_end = 1'b1;
            dest_ptr = dest_ptr + AW'(dest_pitch) - AW'(width);
            if (mode && source_pitch != 0)
               source_ptr = source_ptr + AW'(source_pitch) - AW'(width);
            rows_done = rows_done + DW'(1);
            if (rows_done >= rows_needed) begin
               d.image_done = 1'b1;
               busy = 1'b0;
            end
         end else begin
            dest_ptr = dest_ptr + AW'(copy) + AW'(skip);
            source_ptr = source_ptr + (mode ? AW'(copy) + AW'(skip) : AW'(copy));
         end
         expected_descriptors.push_back(d);
      endfunction

      function void compare_field(string name, longint unsigned exp, longint unsigned act);
         if (exp != act) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, exp, act);
            failures++;
         end
      endfunction

      function void check_descriptor(logic [RDW-1:0] data, logic user, logic last);
         descriptor_type e;
         if (expected_descriptors.size() == 0) begin
            $error("descriptor with none expected: tdata 0x%0h", data);
            failures++;
            return;
         end
         e = expected_descriptors.pop_front();
         compare_field("dest_offset", 64'(e.dest_offset), 64'(data[OW-1:0]));
         compare_field("source_offset", 64'(e.source_offset), 64'(data[2*OW-1:OW]));
         compare_field("copy_length", 64'(e.copy_length), 64'(data[RDW-1:2*OW]));
         compare_field("row_end", 64'(e.row_end), 64'(user));
         compare_field("image_done", 64'(e.image_done), 64'(last));
      endfunction

      function int pending();
         return expected_descriptors.size();
      endfunction
   endclass

   logic           clock = 1'b0;
   logic           reset = 1'b1;
   logic           req_tvalid = 1'b0;
   logic           req_tready;
   logic [QDW-1:0] req_tdata = '0;
   logic           rsp_tvalid;
   logic           rsp_tready = 1'b0;
   logic [RDW-1:0] rsp_tdata;
   logic           rsp_tuser;
   logic           rsp_tlast;
   logic           csr_valid = 1'b0;
   logic           csr_ready;
   logic [CAW-1:0] csr_addr = '0;
   logic [CDW-1:0] csr_wdata = '0;

   descriptor_scoreboard_type sb = new();
   int items_sent = 0;
   int req_idle_odds = 0;
   int rsp_idle_odds = 0;
   int quiet_cycles = 0;

   copy_skip_span_blit_address_gen i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_descriptor(rsp_tdata, rsp_tuser, rsp_tlast);
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("copy_skip_span_blit_address_gen: mismatch");
         $finish;
      end
   end

   initial begin
      @(negedge clock);
      forever begin
         if (rsp_idle_odds != 0 && $urandom_range(0, rsp_idle_odds - 1) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(negedge clock);
      end
   end

   task automatic send_item(bit [CW-1:0] copy, bit [CW-1:0] skip);
      if (req_idle_odds != 0 && $urandom_range(0, req_idle_odds - 1) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {skip, copy};
      do @(posedge clock); while (!req_tready);
      sb.note_instruction(copy, skip);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(cssbag_pkg::reg_index_type idx, bit [CDW-1:0] value);
      csr_valid <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, value);
      @(negedge clock);
   endtask

   task automatic write_all(bit mode, bit [15:0] x, bit [15:0] y, bit [15:0] dpitch,
                            bit [15:0] spitch, bit [11:0] w, bit [11:0] h);
      drain();
      write_reg(cssbag_pkg::REG_SOURCE_MODE, 16'(mode));
      write_reg(cssbag_pkg::REG_DEST_X, x);
      write_reg(cssbag_pkg::REG_DEST_Y, y);
      write_reg(cssbag_pkg::REG_DEST_PITCH, dpitch);
      write_reg(cssbag_pkg::REG_SOURCE_PITCH, spitch);
      write_reg(cssbag_pkg::REG_IMAGE_WIDTH, 16'(w));
      write_reg(cssbag_pkg::REG_IMAGE_HEIGHT, 16'(h));
      csr_valid <= 1'b0;
   endtask

   function automatic bit [15:0] pick16(bit [15:0] lo);
      case ($urandom_range(0, 5))
         0: return lo;
         1: return 16'hffff;
         default: return 16'($urandom_range(lo, 65535));
      endcase
   endfunction

   task automatic randomize_settings();
      bit [11:0] w;
      bit [11:0] h;
      case ($urandom_range(0, 5))
         0: w = 12'hfff;
         1: w = 12'd1;
         default: w = 12'($urandom_range(1, 64));
      endcase
      case ($urandom_range(0, 9))
         0: h = 12'd0;
         1: h = 12'hfff;
         default: h = 12'($urandom_range(1, 6));
      endcase
      write_all(1'($urandom_range(0, 1)), pick16(16'd0), pick16(16'd0), pick16(16'd1),
                ($urandom_range(0, 2) == 0) ? 16'd0 : pick16(16'd1), w, h);
   endtask

   task automatic send_row();
      int spans;
      bit [7:0] copy;
      bit [7:0] skip;
      spans = $urandom_range(0, 5);
      for (int i = 0; i < spans; i++) begin
         copy = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(0, 16));
         skip = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(0, 16));
         if (copy == 0 && skip == 0)
            copy = 8'd1;
         send_item(copy, skip);
      end
      if ($urandom_range(0, 9) == 0)
         send_item(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      send_item(8'd0, 8'd0);
   endtask

   initial begin
      int phase_goal;
      int random_start;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_item(8'd255, 8'd0);
      send_item(8'd0, 8'd255);
      send_item(8'd255, 8'd255);
      send_item(8'd1, 8'd1);
      send_item(8'd0, 8'd0);
      send_item(8'd7, 8'd3);
      send_item(8'd0, 8'd0);

      write_all(1'b1, 16'hffff, 16'hffff, 16'hffff, 16'd0, 12'hfff, 12'd0);
      send_item(8'd10, 8'd5);
      send_item(8'd0, 8'd0);
      send_item(8'd3, 8'd0);
      send_item(8'd0, 8'd0);

      write_all(1'b0, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 12'hfff, 12'd2);
      send_item(8'd0, 8'd0);
      send_item(8'd255, 8'd255);
      send_item(8'd0, 8'd0);

      write_all(1'b1, 16'd0, 16'd0, 16'd1, 16'd1, 12'hfff, 12'hfff);
      send_item(8'd1, 8'd0);
      send_item(8'd0, 8'd0);
      send_item(8'd0, 8'd0);

      write_all(1'b0, 16'd3, 16'd2, 16'd1, 16'd0, 12'd1, 12'd3);
      send_item(8'd4, 8'd200);
      send_item(8'd0, 8'd0);

      random_start = items_sent;
      while (items_sent - random_start < RANDOM_ITEMS) begin
         randomize_settings();
         if (items_sent - random_start >= RANDOM_ITEMS - QUIET_TAIL) begin
            req_idle_odds = 0;
            rsp_idle_odds = 0;
         end else begin
            req_idle_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 8);
            rsp_idle_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 8);
         end
         phase_goal = items_sent + $urandom_range(60, 160);
         while (items_sent < phase_goal)
            send_row();
      end

      drain();
      repeat (10) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0)
         $display("copy_skip_span_blit_address_gen: match");
      else
         $display("copy_skip_span_blit_address_gen: mismatch");
      $finish;
   end

endmodule
